[rtl/umd_pkg.sv]
// Shared widths, state codes and helper types for the uniform motion detector.
// Used by umd_mul, umd_sqrt and uniform_motion_detector; depends on nothing.
package umd_pkg;

	localparam int WINDOW_LEN = 16;
	localparam int DELTA_W    = 16;
	localparam int FLOOR_W    = 16;
	localparam int MAG_W      = 20;
	localparam int EV_W       = 32;
	localparam int FRAC_W     = 4;

	localparam int PSQ_W   = 2 * DELTA_W;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int RAD_W   = 2 * MAG_W;
	localparam int RAD_PAD = RAD_W - PSQ_W;
	localparam int REM_W   = MAG_W + 2;
	localparam int ROOT_CW = $clog2(MAG_W + 1);

	localparam int WIN_AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int FILL_W = $clog2(WINDOW_LEN + 1);
	localparam int S1_W   = MAG_W + $clog2(WINDOW_LEN);
	localparam int S2_W   = SQ_W + $clog2(WINDOW_LEN);

	localparam int RHS_K = 51;
	localparam int LHS_K = 50 * WINDOW_LEN;
	localparam int MEAN_K = 8 * WINDOW_LEN;

	localparam int DIGIT_W   = 4;
	localparam int MUL_AW    = S1_W + 6;
	localparam int MUL_BW    = ((S2_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
	localparam int MUL_PW    = MUL_AW + MUL_BW;
	localparam int MUL_STEPS = MUL_BW / DIGIT_W;
	localparam int STEP_W    = $clog2(MUL_STEPS + 1);

	localparam int IN_W  = 2 * DELTA_W;
	localparam int OUT_W = ((2 + EV_W + 7) / 8) * 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_MSQ,
		ST_UPD,
		ST_RHS_GO,
		ST_RHS,
		ST_LHS,
		ST_OUT
	} umd_state_t;

	typedef enum logic [2:0] {
		OP_SQX,
		OP_SQY,
		OP_MSQ,
		OP_RHS,
		OP_LHS
	} mul_op_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef struct packed {
		logic [SQ_W-1:0]  sq;
		logic [MAG_W-1:0] mag;
	} win_entry_t;

	function automatic logic [DELTA_W-1:0] abs_delta(input logic [DELTA_W-1:0] v);
		return v[DELTA_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

[rtl/umd_mul.sv]
// Digit-serial unsigned multiplier, one radix-16 digit of b per cycle.
// Depends on umd_pkg for widths and the unit status type.
module umd_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [umd_pkg::MUL_AW-1:0]    a,
	input  logic [umd_pkg::MUL_BW-1:0]    b,
	output umd_pkg::unit_stat_t           stat,
	output logic [umd_pkg::MUL_PW-1:0]    product
);

	localparam int SUM_W = umd_pkg::MUL_AW + umd_pkg::DIGIT_W;

	logic [umd_pkg::MUL_AW-1:0] a_q;
	logic [umd_pkg::MUL_AW-1:0] p_q;
	logic [umd_pkg::MUL_BW-1:0] b_q;
	logic [umd_pkg::STEP_W-1:0] cnt_q;
	logic                       done_q;
	logic [SUM_W-1:0]           part;
	logic [SUM_W-1:0]           sum;

	assign part = {{umd_pkg::DIGIT_W{1'b0}}, a_q}
		* {{umd_pkg::MUL_AW{1'b0}}, b_q[umd_pkg::DIGIT_W-1:0]};
	assign sum  = {{umd_pkg::DIGIT_W{1'b0}}, p_q} + part;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= umd_pkg::STEP_W'(umd_pkg::MUL_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == umd_pkg::STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= '0;
		end else if (cnt_q != '0) begin
			b_q <= {sum[umd_pkg::DIGIT_W-1:0], b_q[umd_pkg::MUL_BW-1:umd_pkg::DIGIT_W]};
			p_q <= sum[SUM_W-1:umd_pkg::DIGIT_W];
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign product   = {p_q, b_q};

endmodule

[rtl/umd_sqrt.sv]
// Restoring integer square root, one result bit per cycle.
// Depends on umd_pkg for widths and the unit status type.
module umd_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [umd_pkg::RAD_W-1:0]    radicand,
	output umd_pkg::unit_stat_t          stat,
	output logic [umd_pkg::MAG_W-1:0]    root
);

	localparam int TRY_W = umd_pkg::REM_W + 2;

	logic [umd_pkg::RAD_W-1:0]   rad_q;
	logic [umd_pkg::REM_W-1:0]   rem_q;
	logic [umd_pkg::MAG_W-1:0]   root_q;
	logic [umd_pkg::ROOT_CW-1:0] cnt_q;
	logic                        done_q;
	logic [TRY_W-1:0]            remv;
	logic [TRY_W-1:0]            trial;
	logic [TRY_W-1:0]            diff;
	logic                        fits;

	assign remv  = {rem_q, rad_q[umd_pkg::RAD_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = (remv >= trial);
	assign diff  = remv - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= umd_pkg::ROOT_CW'(umd_pkg::MAG_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == umd_pkg::ROOT_CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q <= {rad_q[umd_pkg::RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= diff[umd_pkg::REM_W-1:0];
				root_q <= {root_q[umd_pkg::MAG_W-2:0], 1'b1};
			end else begin
				rem_q  <= remv[umd_pkg::REM_W-1:0];
				root_q <= {root_q[umd_pkg::MAG_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

[rtl/uniform_motion_detector.sv]
// Uniform motion detector top level: control sequencer, window store and verdict state.
// Depends on umd_pkg, umd_mul and umd_sqrt.
//
// Usage:
//   Slave stream s_*: one request per motion delta. s_tdata = {dy, dx}, s_tuser = action
//   (0 reference sample, 1 observed sample). Master stream m_*: one result per request,
//   m_tdata = {pad, event_total, jump_seen, is_human}. cfg_we/cfg_wdata load jump_floor.
//   Each request is worked on alone, through the shared radix-16 multiplier and the
//   bit-serial square root. A reference sample needs two products and one root, an
//   observed sample three products and one root while the window fills and five
//   products and one root once it is full. The next request is only taken after the
//   result of the last one is loaded into the output register.
//   s_tready rises again once the result sits in the output register, so the next
//   request is taken while the receiver stalls; the result is only overwritten after
//   it is taken. Reset clears the sums, peak, event count and window fill, sets the
//   verdict to human and jump_floor to 80. The window memory needs no clearing: an
//   entry is only read back after it has been written.
module uniform_motion_detector (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [umd_pkg::IN_W-1:0]          s_tdata,   // dx[15:0], dy[31:16]
	input  logic                              s_tuser,   // action
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [umd_pkg::OUT_W-1:0]         m_tdata,   // is_human, jump_seen, event_total
	input  logic                              cfg_we,
	input  logic [umd_pkg::FLOOR_W-1:0]       cfg_wdata  // jump_floor
);

	umd_pkg::umd_state_t state_q, state_d;
	umd_pkg::mul_op_t    mul_op;
	umd_pkg::unit_stat_t mul_st, root_st;

	logic                          mul_start, root_start, out_load, accept;
	logic [umd_pkg::MUL_AW-1:0]    mul_a;
	logic [umd_pkg::MUL_BW-1:0]    mul_b;
	logic [umd_pkg::MUL_PW-1:0]    mul_p;
	logic [umd_pkg::RAD_W-1:0]     radicand;
	logic [umd_pkg::MAG_W-1:0]     root;
	logic [umd_pkg::PSQ_W-1:0]     sq_sum;

	logic                          action_q, jump_q, verdict_q, m_tvalid_q;
	logic [umd_pkg::DELTA_W-1:0]   ady_q;
	logic [umd_pkg::PSQ_W-1:0]     sqx_q;
	logic [umd_pkg::MAG_W-1:0]     mag_q, peak_q;
	logic [umd_pkg::SQ_W-1:0]      magsq_q;
	logic [umd_pkg::MUL_PW-1:0]    rhs_q;
	logic [umd_pkg::FLOOR_W-1:0]   floor_q;
	logic [umd_pkg::WIN_AW-1:0]    head_q;
	logic [umd_pkg::FILL_W-1:0]    fill_q;
	logic [umd_pkg::S1_W-1:0]      s1_q, s1_base, s1_d;
	logic [umd_pkg::S2_W-1:0]      s2_q, s2_base, s2_d;
	logic [umd_pkg::EV_W-1:0]      event_q, event_inc;
	logic [umd_pkg::OUT_W-1:0]     m_data_q;

	umd_pkg::win_entry_t           mem_q [umd_pkg::WINDOW_LEN];
	umd_pkg::win_entry_t           old_q;

	logic [umd_pkg::MAG_W-1:0]     floor_q4, bar;
	logic                          jump_now, full_before, full_after, uniform;

	umd_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.stat    (mul_st),
		.product (mul_p)
	);

	umd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (radicand),
		.stat     (root_st),
		.root     (root)
	);

	assign accept   = s_tvalid && s_tready;
	assign sq_sum   = sqx_q + mul_p[umd_pkg::PSQ_W-1:0];
	assign radicand = {sq_sum, {umd_pkg::RAD_PAD{1'b0}}};

	// jump bar and window bookkeeping for the update step
	assign floor_q4    = {floor_q, {umd_pkg::FRAC_W{1'b0}}};
	assign bar         = (peak_q > floor_q4) ? peak_q : floor_q4;
	assign jump_now    = (mag_q > bar);
	assign full_before = (fill_q == umd_pkg::FILL_W'(umd_pkg::WINDOW_LEN));
	assign full_after  = full_before || (fill_q == umd_pkg::FILL_W'(umd_pkg::WINDOW_LEN - 1));
	assign s1_base     = full_before ? (s1_q - umd_pkg::S1_W'(old_q.mag)) : s1_q;
	assign s1_d        = s1_base + umd_pkg::S1_W'(mag_q);
	assign s2_base     = full_before ? (s2_q - umd_pkg::S2_W'(old_q.sq)) : s2_q;
	assign s2_d        = s2_base + umd_pkg::S2_W'(magsq_q);
	assign event_inc   = (event_q == '1) ? event_q : (event_q + 1'b1);
	assign uniform     = (s1_q > umd_pkg::S1_W'(umd_pkg::MEAN_K)) && (mul_p < rhs_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			umd_pkg::ST_IDLE:   if (s_tvalid) state_d = umd_pkg::ST_SQX;
			umd_pkg::ST_SQX:    if (mul_st.done) state_d = umd_pkg::ST_SQY;
			umd_pkg::ST_SQY:    if (mul_st.done) state_d = umd_pkg::ST_ROOT;
			umd_pkg::ST_ROOT: begin
				if (root_st.done) state_d = action_q ? umd_pkg::ST_MSQ : umd_pkg::ST_OUT;
			end
			umd_pkg::ST_MSQ:    if (mul_st.done) state_d = umd_pkg::ST_UPD;
			umd_pkg::ST_UPD:    state_d = full_after ? umd_pkg::ST_RHS_GO : umd_pkg::ST_OUT;
			umd_pkg::ST_RHS_GO: state_d = umd_pkg::ST_RHS;
			umd_pkg::ST_RHS:    if (mul_st.done) state_d = umd_pkg::ST_LHS;
			umd_pkg::ST_LHS:    if (mul_st.done) state_d = umd_pkg::ST_OUT;
			umd_pkg::ST_OUT:    if (!m_tvalid_q || m_tready) state_d = umd_pkg::ST_IDLE;
			default:            state_d = umd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		mul_start  = 1'b0;
		root_start = 1'b0;
		out_load   = 1'b0;
		mul_op     = umd_pkg::OP_SQX;
		unique case (state_q)
			umd_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				mul_start = s_tvalid;
			end
			umd_pkg::ST_SQX: begin
				mul_start = mul_st.done;
				mul_op    = umd_pkg::OP_SQY;
			end
			umd_pkg::ST_SQY:    root_start = mul_st.done;
			umd_pkg::ST_ROOT: begin
				mul_start = root_st.done && action_q;
				mul_op    = umd_pkg::OP_MSQ;
			end
			umd_pkg::ST_RHS_GO: begin
				mul_start = 1'b1;
				mul_op    = umd_pkg::OP_RHS;
			end
			umd_pkg::ST_RHS: begin
				mul_start = mul_st.done;
				mul_op    = umd_pkg::OP_LHS;
			end
			umd_pkg::ST_OUT:    out_load = !m_tvalid_q || m_tready;
			default: begin
			end
		endcase
	end

	always_comb begin
		unique case (mul_op)
			umd_pkg::OP_SQX: begin
				mul_a = umd_pkg::MUL_AW'(umd_pkg::abs_delta(s_tdata[umd_pkg::DELTA_W-1:0]));
				mul_b = umd_pkg::MUL_BW'(umd_pkg::abs_delta(s_tdata[umd_pkg::DELTA_W-1:0]));
			end
			umd_pkg::OP_SQY: begin
				mul_a = umd_pkg::MUL_AW'(ady_q);
				mul_b = umd_pkg::MUL_BW'(ady_q);
			end
			umd_pkg::OP_MSQ: begin
				mul_a = umd_pkg::MUL_AW'(root);
				mul_b = umd_pkg::MUL_BW'(root);
			end
			umd_pkg::OP_RHS: begin
				mul_a = umd_pkg::MUL_AW'(s1_q) * umd_pkg::MUL_AW'(umd_pkg::RHS_K);
				mul_b = umd_pkg::MUL_BW'(s1_q);
			end
			umd_pkg::OP_LHS: begin
				mul_a = umd_pkg::MUL_AW'(umd_pkg::LHS_K);
				mul_b = umd_pkg::MUL_BW'(s2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= umd_pkg::ST_IDLE;
			action_q   <= 1'b0;
			jump_q     <= 1'b0;
			verdict_q  <= 1'b1;
			peak_q     <= '0;
			floor_q    <= umd_pkg::FLOOR_W'(80);
			head_q     <= '0;
			fill_q     <= '0;
			s1_q       <= '0;
			s2_q       <= '0;
			event_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) floor_q <= cfg_wdata;
			if (accept) begin
				action_q <= s_tuser;
				jump_q   <= 1'b0;
			end
			if (state_q == umd_pkg::ST_ROOT && root_st.done && !action_q && root > peak_q) begin
				peak_q <= root;
			end
			if (state_q == umd_pkg::ST_UPD) begin
				jump_q <= jump_now;
				s1_q   <= s1_d;
				s2_q   <= s2_d;
				head_q <= (head_q == umd_pkg::WIN_AW'(umd_pkg::WINDOW_LEN - 1)) ? '0
					: head_q + 1'b1;
				if (!full_before) fill_q <= fill_q + 1'b1;
				if (jump_now) event_q <= event_inc;
				if (!full_after) verdict_q <= !jump_now;
			end
			if (state_q == umd_pkg::ST_LHS && mul_st.done) begin
				if (uniform) begin
					verdict_q <= 1'b0;
					if (!jump_q) event_q <= event_inc;
				end else begin
					verdict_q <= !jump_q;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) ady_q <= umd_pkg::abs_delta(s_tdata[umd_pkg::IN_W-1:umd_pkg::DELTA_W]);
		if (state_q == umd_pkg::ST_SQX && mul_st.done) sqx_q <= mul_p[umd_pkg::PSQ_W-1:0];
		if (state_q == umd_pkg::ST_ROOT && root_st.done) mag_q <= root;
		if (state_q == umd_pkg::ST_MSQ && mul_st.done) magsq_q <= mul_p[umd_pkg::SQ_W-1:0];
		if (state_q == umd_pkg::ST_RHS && mul_st.done) rhs_q <= mul_p;
		if (out_load) m_data_q <= umd_pkg::OUT_W'({event_q, jump_q, verdict_q});
	end

	// window store: read the slot about to be replaced at accept, write it back at update
	always_ff @(posedge clk) begin
		if (state_q == umd_pkg::ST_UPD) mem_q[head_q] <= {magsq_q, mag_q};
		if (accept) old_q <= mem_q[head_q];
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		mul_st.done |-> !root_st.busy)
		else $error("multiplier finished while square root running");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= umd_pkg::FILL_W'(umd_pkg::WINDOW_LEN))
		else $error("window fill beyond window length");

	a_events_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> event_q >= $past(event_q))
		else $error("event count decreased");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready && mul_st.busy)
		else $error("request accepted without starting the multiplier");

endmodule
